[hw/rtl/sdtq_pkg.sv]
// Shared types and constants for the sorted deadline timer queue.
package sdtq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W        = 32;
    localparam int DELAY_W       = 16;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_ALARM = 2'd1,
        OP_POP   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_INS_RD   = 10'b00_0000_0010,
        ST_INS_CMP  = 10'b00_0000_0100,
        ST_INS_PUT  = 10'b00_0000_1000,
        ST_REP_RD   = 10'b00_0001_0000,
        ST_REP_CMP  = 10'b00_0010_0000,
        ST_POP_RD   = 10'b00_0100_0000,
        ST_POP_HEAD = 10'b00_1000_0000,
        ST_POP_MOV  = 10'b01_0000_0000,
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_cmp;
        logic ins_put;
        logic rep_rd;
        logic rep_cmp;
        logic pop_rd;
        logic pop_head;
        logic pop_mov;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_op;
        logic       full;
        logic       empty;
        logic       count_one;
        logic       ptr_one;
        logic       ptr_last;
        logic       gt_when;
        logic       gt_now;
        logic       out_free;
    } status_t;

endpackage

[hw/rtl/sdtq_req_if.sv]
// Request channel: operation, current time and delay.
interface sdtq_req_if import sdtq_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [TIME_W-1:0]  now_seconds;
    logic [DELAY_W-1:0] delay_seconds;

    modport source (output valid, operation, now_seconds, delay_seconds, input ready);
    modport sink   (input valid, operation, now_seconds, delay_seconds, output ready);
endinterface

[hw/rtl/sdtq_rsp_if.sv]
// Result channel: alarm report, popped deadline, fill level and error code.
interface sdtq_rsp_if import sdtq_pkg::*; #(
    parameter int CNT_W = $clog2(DEPTH_DEFAULT + 1)
);
    logic              valid;
    logic              ready;
    logic              alarm_valid;
    logic [TIME_W-1:0] alarm_delay;
    logic [TIME_W-1:0] popped_deadline;
    logic [CNT_W-1:0]  entry_count;
    logic [1:0]        error_code;

    modport source (output valid, alarm_valid, alarm_delay, popped_deadline, entry_count,
                    error_code, input ready);
    modport sink   (input valid, alarm_valid, alarm_delay, popped_deadline, entry_count,
                    error_code, output ready);
endinterface

[hw/rtl/sdtq_ctrl.sv]
// Controller state machine: sequences insert, report and pop passes.
module sdtq_ctrl import sdtq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign fire      = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    unique case (status.req_op)
                        OP_SET:
                        begin
                            priority if (status.full)  state_next = ST_REP_RD;
                            else if (status.empty)     state_next = ST_INS_PUT;
                            else                       state_next = ST_INS_RD;
                        end
                        OP_ALARM: state_next = status.empty ? ST_DONE : ST_REP_RD;
                        OP_POP:   state_next = status.empty ? ST_DONE : ST_POP_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS_RD:  state_next = ST_INS_CMP;
            ST_INS_CMP:
            begin
                priority if (!status.gt_when) state_next = ST_REP_RD;
                else if (status.ptr_one)      state_next = ST_INS_PUT;
                else                          state_next = ST_INS_CMP;
            end
            ST_INS_PUT: state_next = ST_REP_RD;
            ST_REP_RD:  state_next = ST_REP_CMP;
            ST_REP_CMP:
            begin
                if (status.gt_now || status.ptr_last)
                    state_next = ST_DONE;
            end
            ST_POP_RD:   state_next = ST_POP_HEAD;
            ST_POP_HEAD: state_next = status.count_one ? ST_DONE : ST_POP_MOV;
            ST_POP_MOV:
            begin
                if (status.ptr_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = fire;
        cmd.ins_rd   = (state_reg == ST_INS_RD);
        cmd.ins_cmp  = (state_reg == ST_INS_CMP);
        cmd.ins_put  = (state_reg == ST_INS_PUT);
        cmd.rep_rd   = (state_reg == ST_REP_RD);
        cmd.rep_cmp  = (state_reg == ST_REP_CMP);
        cmd.pop_rd   = (state_reg == ST_POP_RD);
        cmd.pop_head = (state_reg == ST_POP_HEAD);
        cmd.pop_mov  = (state_reg == ST_POP_MOV);
        cmd.out_load = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

[hw/rtl/sdtq_datapath.sv]
// Datapath: deadline memory, scan pointer, fill count and result register.
module sdtq_datapath import sdtq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         req_op,
    input  logic [TIME_W-1:0]  req_now,
    input  logic [DELAY_W-1:0] req_delay,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic               rsp_alarm_valid,
    output logic [TIME_W-1:0]  rsp_alarm_delay,
    output logic [TIME_W-1:0]  rsp_popped,
    output logic [CNT_W-1:0]   rsp_count,
    output logic [1:0]         rsp_error
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    logic [TIME_W-1:0] now_reg, when_reg;
    logic [TIME_W-1:0] when_calc;
    logic [TIME_W:0]   sum;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  ptr_m1, ptr_m2, ptr_p1;

    logic              alarm_valid_reg, alarm_valid_next;
    logic [TIME_W-1:0] alarm_delay_reg, alarm_delay_next;
    logic [TIME_W-1:0] popped_reg, popped_next;
    err_t              err_reg, err_next;

    logic              out_valid_reg;
    logic              out_alarm_valid_reg;
    logic [TIME_W-1:0] out_alarm_delay_reg;
    logic [TIME_W-1:0] out_popped_reg;
    logic [CNT_W-1:0]  out_count_reg;
    err_t              out_err_reg;

    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              gt_when, gt_now, ptr_last, ptr_one;

    assign sum       = {1'b0, req_now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, req_delay};
    assign when_calc = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign ptr_m2   = ptr_reg - CNT_W'(2);
    assign ptr_p1   = ptr_reg + CNT_W'(1);
    assign gt_when  = rd_data_reg > when_reg;
    assign gt_now   = rd_data_reg > now_reg;
    assign ptr_last = (ptr_p1 == count_reg);
    assign ptr_one  = (ptr_reg == CNT_W'(1));

    always_comb
    begin
        status           = '0;
        status.req_op    = req_op;
        status.full      = (count_reg == CNT_W'(DEPTH));
        status.empty     = (count_reg == '0);
        status.count_one = (count_reg == CNT_W'(1));
        status.ptr_one   = ptr_one;
        status.ptr_last  = ptr_last;
        status.gt_when   = gt_when;
        status.gt_now    = gt_now;
        status.out_free  = !out_valid_reg || rsp_ready;
    end

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = ptr_reg[IDX_W-1:0];
        wr_data = when_reg;
        if (cmd.ins_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_m1[IDX_W-1:0];
        end
        if (cmd.ins_cmp)
        begin
            wr_en = 1'b1;
            if (gt_when)
            begin
                wr_data = rd_data_reg;
                rd_en   = !ptr_one;
                rd_addr = ptr_m2[IDX_W-1:0];
            end
        end
        if (cmd.ins_put)
            wr_en = 1'b1;
        if (cmd.rep_rd || cmd.pop_rd)
            rd_en = 1'b1;
        if ((cmd.rep_cmp && !gt_now && !ptr_last) || (cmd.pop_mov && !ptr_last))
        begin
            rd_en   = 1'b1;
            rd_addr = ptr_p1[IDX_W-1:0];
        end
        if (cmd.pop_head && !status.count_one)
        begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(1);
        end
        if (cmd.pop_mov)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_m1[IDX_W-1:0];
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // pointer, count and result fields
    always_comb
    begin
        ptr_next         = ptr_reg;
        count_next       = count_reg;
        alarm_valid_next = alarm_valid_reg;
        alarm_delay_next = alarm_delay_reg;
        popped_next      = popped_reg;
        err_next         = err_reg;
        if (cmd.load)
        begin
            ptr_next         = (req_op == OP_SET) ? count_reg : '0;
            alarm_valid_next = 1'b0;
            alarm_delay_next = '0;
            popped_next      = '0;
            err_next         = ERR_OK;
            if (req_op == OP_SET && status.full)
                err_next = ERR_FULL;
            if (req_op == OP_POP && status.empty)
                err_next = ERR_EMPTY;
        end
        if (cmd.ins_cmp)
        begin
            if (gt_when)
                ptr_next = ptr_m1;
            else
                count_next = count_reg + CNT_W'(1);
        end
        if (cmd.ins_put)
            count_next = count_reg + CNT_W'(1);
        if (cmd.rep_rd || cmd.pop_rd)
            ptr_next = '0;
        if (cmd.rep_cmp)
        begin
            if (gt_now)
            begin
                alarm_valid_next = 1'b1;
                alarm_delay_next = rd_data_reg - now_reg;
            end
            else if (!ptr_last)
                ptr_next = ptr_p1;
        end
        if (cmd.pop_head)
        begin
            popped_next = rd_data_reg;
            ptr_next    = CNT_W'(1);
            if (status.count_one)
                count_next = count_reg - CNT_W'(1);
        end
        if (cmd.pop_mov)
        begin
            if (ptr_last)
                count_next = count_reg - CNT_W'(1);
            else
                ptr_next = ptr_p1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= req_now;
            when_reg <= when_calc;
        end
        alarm_valid_reg <= alarm_valid_next;
        alarm_delay_reg <= alarm_delay_next;
        popped_reg      <= popped_next;
        err_reg         <= err_next;
        if (cmd.out_load)
        begin
            out_alarm_valid_reg <= alarm_valid_reg;
            out_alarm_delay_reg <= alarm_delay_reg;
            out_popped_reg      <= popped_reg;
            out_count_reg       <= count_reg;
            out_err_reg         <= err_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_alarm_valid = out_alarm_valid_reg;
    assign rsp_alarm_delay = out_alarm_delay_reg;
    assign rsp_popped      = out_popped_reg;
    assign rsp_count       = out_count_reg;
    assign rsp_error       = out_err_reg;

endmodule

[hw/rtl/sorted_deadline_timer_queue.sv]
// Top level of the sorted deadline timer queue.
//
// Keeps up to DEPTH absolute deadlines in ascending order in a single-port-write,
// registered-read memory and answers each request with one result. One request is
// worked at a time. A set-timer request shifts up the entries past the new deadline,
// then scans entries for the first future deadline; into an empty queue it writes the
// deadline straight away, and into a full one it only scans. An alarm request scans,
// a pop request moves every remaining stored entry down by one, and an alarm or pop on
// an empty queue or an unused operation goes straight to the result. The block is ready
// for the next request once the result is raised. The memory port moves or compares
// one entry per cycle. A finished result sits in an output register, so a stalled
// result channel holds the block only once the next result is ready. Deadlines that
// have expired stay stored until popped.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    sdtq_req_if.sink   req,
    sdtq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t    cmd;
    status_t status;

    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sdtq_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_op          (req.operation),
        .req_now         (req.now_seconds),
        .req_delay       (req.delay_seconds),
        .cmd             (cmd),
        .status          (status),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_alarm_valid (rsp.alarm_valid),
        .rsp_alarm_delay (rsp.alarm_delay),
        .rsp_popped      (rsp.popped_deadline),
        .rsp_count       (rsp.entry_count),
        .rsp_error       (rsp.error_code)
    );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sorted deadline timer queue: shadow model, random traffic.
module tb_top;
    import sdtq_pkg::*;

    localparam int          QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int          CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          RANDOM_REQS = 1100;
    localparam int          HOLD_CYCLES = 300;
    localparam int          DRAIN_WAIT  = 2 * QUEUE_DEPTH + 10;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          MAX_REPORTS = 200;

    typedef struct packed {
        logic [1:0]         op;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
    } timer_req_t;

    typedef struct packed {
        logic              alarm_valid;
        logic [TIME_W-1:0] alarm_delay;
        logic [TIME_W-1:0] popped;
        logic [CNT_W-1:0]  count;
        err_t              err;
    } timer_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    sdtq_req_if                      req_ch ();
    sdtq_rsp_if #(.CNT_W(CNT_W))     rsp_ch ();

    sorted_deadline_timer_queue #(.DEPTH(QUEUE_DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [TIME_W-1:0] shadow_deadlines [$];

    timer_req_t   timer_requests [$];
    timer_reply_t timer_replies_due [$];

    int          mismatches   = 0;
    int          replies_seen = 0;
    int          next_hold_at = 250;
    int          hold_left    = 0;
    int          cycle_count  = 0;
    int          tx_wait;
    int          rx_wait;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    timer_req_t  offered;

    function automatic logic [TIME_W:0] next_future_deadline(logic [TIME_W-1:0] now);
        for (int i = 0; i < shadow_deadlines.size(); i++)
        begin
            if (shadow_deadlines[i] > now)
                return {1'b1, shadow_deadlines[i] - now};
        end
        return '0;
    endfunction

    function automatic timer_reply_t advance_shadow_queue(timer_req_t r);
        timer_reply_t     res;
        logic [TIME_W:0]  sum;
        logic [TIME_W-1:0] when;
        int               pos;
        res = '0;
        res.err = ERR_OK;
        case (r.op)
            OP_SET:
            begin
                sum  = {1'b0, r.now} + (TIME_W + 1)'(r.delay);
                when = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                if (shadow_deadlines.size() >= QUEUE_DEPTH)
                    res.err = ERR_FULL;
                else
                begin
                    pos = 0;
                    while (pos < shadow_deadlines.size() && shadow_deadlines[pos] <= when)
                        pos++;
                    shadow_deadlines.insert(pos, when);
                end
                {res.alarm_valid, res.alarm_delay} = next_future_deadline(r.now);
            end
            OP_ALARM:
                {res.alarm_valid, res.alarm_delay} = next_future_deadline(r.now);
            OP_POP:
            begin
                if (shadow_deadlines.size() == 0)
                    res.err = ERR_EMPTY;
                else
                    res.popped = shadow_deadlines.pop_front();
            end
            default:
            begin
            end
        endcase
        res.count = CNT_W'(shadow_deadlines.size());
        return res;
    endfunction

    function automatic void check_field(string name, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic add_request(logic [1:0] op, logic [TIME_W-1:0] now,
                               logic [DELAY_W-1:0] delay);
        timer_req_t r;
        r.op    = op;
        r.now   = now;
        r.delay = delay;
        timer_requests.push_back(r);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.operation     <= OP_SET;
            req_ch.now_seconds   <= '0;
            req_ch.delay_seconds <= '0;
            tx_wait = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                timer_replies_due.push_back(advance_shadow_queue(offered));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    req_ch.valid <= 1'b0;
                end
                else if (timer_requests.size() > 0)
                begin
                    offered = timer_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.operation     <= offered.op;
                    req_ch.now_seconds   <= offered.now;
                    req_ch.delay_seconds <= offered.delay;
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = !tx_burst;
                    tx_wait = tx_burst ? 0 : $urandom_range(0, 3);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge clk or negedge rst_n)
    begin
        timer_reply_t exp;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                replies_seen <= replies_seen + 1;
                if (timer_replies_due.size() == 0)
                begin
                    mismatches++;
                    $display({"%0t: reply with none expected, expected none, ",
                              "actual %0h/%0h/%0h/%0h/%0h"},
                             $time, rsp_ch.alarm_valid, rsp_ch.alarm_delay,
                             rsp_ch.popped_deadline, rsp_ch.entry_count, rsp_ch.error_code);
                end
                else
                begin
                    exp = timer_replies_due.pop_front();
                    check_field("alarm_valid", TIME_W'(exp.alarm_valid),
                                TIME_W'(rsp_ch.alarm_valid));
                    check_field("alarm_delay", exp.alarm_delay, rsp_ch.alarm_delay);
                    check_field("popped_deadline", exp.popped, rsp_ch.popped_deadline);
                    check_field("entry_count", TIME_W'(exp.count),
                                TIME_W'(rsp_ch.entry_count));
                    check_field("error_code", TIME_W'(exp.err), TIME_W'(rsp_ch.error_code));
                end
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
            end
            if (hold_left > 0)
                rsp_ch.ready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // long reply hold-off so the block backs up into the request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left == 0 && replies_seen >= next_hold_at)
        begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 450;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [TIME_W-1:0]  base_now;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
        logic [1:0]         op;
        int                 mode;
        int                 roll;

        rst_n = 1'b0;

        // directed: empty queue, saturation, equal deadlines, expired entries, drain
        add_request(OP_POP,    32'h0,         16'h0);
        add_request(OP_ALARM,  32'h0,         16'h0);
        add_request(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        add_request(OP_SET,    32'h0,         16'h0);
        add_request(OP_SET,    32'd100,       16'h0);
        add_request(OP_SET,    32'h0,         16'hFFFF);
        add_request(OP_SET,    32'hFFFF_0000, 16'hFFFF);
        add_request(OP_SET,    32'hFFFF_FFFF, 16'hFFFF);
        add_request(OP_SET,    32'hFFFF_FFFF, 16'h1);
        add_request(OP_ALARM,  32'hFFFF_FFFE, 16'hFFFF);
        add_request(OP_ALARM,  32'hFFFF_FFFF, 16'h0);
        add_request(OP_SET,    32'd100,       16'h0);
        add_request(OP_ALARM,  32'd50,        16'h0);
        add_request(OP_UNUSED, 32'h0,         16'h0);
        repeat (8)
            add_request(OP_POP, 32'h5555_AAAA, 16'hA5A5);

        base_now = $urandom();
        mode = 0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 60 == 0)
                mode = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            case (mode)
                0:       op = roll < 70 ? OP_SET : roll < 85 ? OP_ALARM :
                              roll < 97 ? OP_POP : OP_UNUSED;
                1:       op = roll < 20 ? OP_SET : roll < 35 ? OP_ALARM :
                              roll < 97 ? OP_POP : OP_UNUSED;
                default: op = roll < 40 ? OP_SET : roll < 70 ? OP_ALARM :
                              roll < 97 ? OP_POP : OP_UNUSED;
            endcase
            roll = $urandom_range(0, 199);
            if (roll == 0)
                base_now = $urandom_range(32'hFFFE_0000, 32'hFFFF_FFFF);
            else if (roll == 1)
                base_now = $urandom();
            else
                base_now = base_now + $urandom_range(0, 40);
            roll = $urandom_range(0, 99);
            now = roll < 6 ? $urandom() : roll < 9 ? 32'h0 : roll < 12 ? 32'hFFFF_FFFF :
                  base_now - $urandom_range(0, 30);
            roll = $urandom_range(0, 99);
            delay = roll < 10 ? 16'h0 : roll < 15 ? 16'hFFFF : roll < 40 ? 16'($urandom()) :
                    16'($urandom_range(1, 200));
            add_request(op, now, delay);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (timer_requests.size() > 0 || req_ch.valid || timer_replies_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (mismatches == 0 && timer_replies_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sorted_deadline_timer_queue.f]
hw/rtl/sdtq_pkg.sv
hw/rtl/sdtq_req_if.sv
hw/rtl/sdtq_rsp_if.sv
hw/rtl/sdtq_ctrl.sv
hw/rtl/sdtq_datapath.sv
hw/rtl/sorted_deadline_timer_queue.sv
tb/tb_top.sv
